FILE: sv/rrts_pkg.sv
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int PTR_W       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int FILL_W      = $clog2(MAX_THREADS + 1);
  localparam int ID_W        = 4;
  localparam int TIME_W      = 16;
  localparam int OP_W        = 3;
  localparam int RC_W        = 5;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_READY  = 3'd0,
    OP_TICK       = 3'd1,
    OP_FINISHED   = 3'd2,
    OP_BLOCKED    = 3'd3,
    OP_NOTIFY_ONE = 3'd4,
    OP_WAKE_ALL   = 3'd5
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_INCREMENT = 2'd1;

  // queue request and queue status
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              empty;
    logic              full;
  } q_stat_t;

  // thread number to counter slot, modulo MAX_THREADS
  function automatic logic [PTR_W-1:0] slot_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] v;
    v = id;
    for (int i = 0; i < 8; i++) begin
      if (MAX_THREADS < (1 << ID_W) && int'(v) >= MAX_THREADS) begin
        v = v - ID_W'(MAX_THREADS);
      end
    end
    return PTR_W'(v);
  endfunction

endpackage

FILE: sv/rrts_queue.sv
`timescale 1ns / 1ps
module rrts_queue
  import rrts_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  q_ctrl_t         ctrl,
  input  logic [ID_W-1:0] push_data,
  output logic [ID_W-1:0] head_data,
  output q_stat_t         stat
);

  localparam int SUM_W = FILL_W + 1;

  logic [ID_W-1:0]   mem [MAX_THREADS];
  logic [PTR_W-1:0]  head;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  wsum;
  logic [PTR_W-1:0]  waddr;
  logic              full;
  logic              push_ok;

  assign full    = (fill == FILL_W'(MAX_THREADS));
  assign push_ok = ctrl.push && (!full || ctrl.pop);

  // slot behind the last entry; taken before any pop in the same cycle
  assign wsum  = SUM_W'(head) + SUM_W'(fill);
  assign waddr = (wsum >= SUM_W'(MAX_THREADS)) ? PTR_W'(wsum - SUM_W'(MAX_THREADS))
                                               : PTR_W'(wsum);

  assign head_data  = mem[head];
  assign stat.fill  = fill;
  assign stat.empty = (fill == '0);
  assign stat.full  = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      if (ctrl.pop) begin
        head <= (head == PTR_W'(MAX_THREADS - 1)) ? '0 : head + 1'b1;
      end
      fill <= fill + FILL_W'(push_ok) - FILL_W'(ctrl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[waddr] <= push_data;
    end
  end

endmodule

FILE: sv/rrts_slice.sv
`timescale 1ns / 1ps
module rrts_slice
  import rrts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ID_W-1:0]   id,
  input  logic [TIME_W-1:0] tick_inc,
  input  logic [TIME_W-1:0] slice_len,
  input  logic              update,
  output logic              expire
);

  logic [TIME_W-1:0] used [MAX_THREADS];
  logic [PTR_W-1:0]  slot;
  logic [TIME_W:0]   sum;

  assign slot   = slot_of(id);
  assign sum    = {1'b0, used[slot]} + {1'b0, tick_inc};
  assign expire = (sum >= {1'b0, slice_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        used[i] <= '0;
      end
    end else if (update) begin
      used[slot] <= expire ? '0 : sum[TIME_W-1:0];
    end
  end

endmodule

FILE: sv/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser: op; s_tdata: thread_id
// m_*      out  m_tvalid/m_tready  m_tdata: running_id, running_idle, status, ready_count
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// An accepted beat passes accept (S_IDLE), execute (S_EXEC) and result load (S_RESULT).
// A wake-all beat adds S_WALK before result load: the queue transfer step moves one
// thread per cycle until the blocked queue empties or ready fills.
// One beat in flight; s_tready is low until its result is loaded.
// rst (sync, active high) empties both queues, clears all slice counters, goes idle.
// m_tready low holds the result and blocks the next load, so the next beat waits in S_RESULT.
module round_robin_thread_scheduler
  import rrts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [3:0] thread_id, [7:4] zero
  input  logic [2:0]           s_tuser,   // [2:0] op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [3:0] running_id, [4] running_idle,
                                          // [5] status, [10:6] ready_count, [15:11] zero
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_RESULT} state_t;

  state_t            state;
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   tid_r;
  logic [ID_W-1:0]   current_id;
  logic              idle_flag;
  logic              status;
  logic [TIME_W-1:0] slice_length;
  logic [TIME_W-1:0] tick_increment;

  q_ctrl_t         rq_ctrl, bq_ctrl;
  q_stat_t         rq_stat, bq_stat;
  logic [ID_W-1:0] rq_push_data, rq_head;
  logic [ID_W-1:0] bq_head;
  logic            slice_upd, expire;
  logic            wake;
  logic            dispatch;
  logic            load_result;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  rrts_queue u_ready (
    .clk(clk), .rst(rst), .ctrl(rq_ctrl), .push_data(rq_push_data),
    .head_data(rq_head), .stat(rq_stat)
  );

  rrts_queue u_blocked (
    .clk(clk), .rst(rst), .ctrl(bq_ctrl), .push_data(current_id),
    .head_data(bq_head), .stat(bq_stat)
  );

  rrts_slice u_slice (
    .clk(clk), .rst(rst), .id(current_id), .tick_inc(tick_increment),
    .slice_len(slice_length), .update(slice_upd), .expire(expire)
  );

  // one blocked-to-ready transfer step
  assign wake = ((state == S_EXEC) && (op_r == OP_NOTIFY_ONE)) || (state == S_WALK);

  // result register free or being drained this cycle
  assign load_result = (state == S_RESULT) && (!m_tvalid || m_tready);

  always_comb begin
    rq_ctrl      = '0;
    bq_ctrl      = '0;
    rq_push_data = tid_r;
    slice_upd    = 1'b0;
    dispatch     = 1'b0;
    if (state == S_EXEC) begin
      unique case (op_r)
        OP_ADD_READY: rq_ctrl.push = 1'b1;
        OP_TICK: begin
          if (idle_flag) begin
            dispatch = 1'b1;
          end else begin
            slice_upd = 1'b1;
            // rotate: head leaves, running thread goes to the back
            if (expire && !rq_stat.empty) begin
              rq_ctrl.pop  = 1'b1;
              rq_ctrl.push = 1'b1;
              rq_push_data = current_id;
            end
          end
        end
        OP_FINISHED: dispatch = 1'b1;
        OP_BLOCKED: begin
          bq_ctrl.push = !idle_flag;
          dispatch     = 1'b1;
        end
        default: ;
      endcase
      if (dispatch) begin
        rq_ctrl.pop = !rq_stat.empty;
      end
    end
    if (wake && !bq_stat.empty && !rq_stat.full) begin
      bq_ctrl.pop  = 1'b1;
      rq_ctrl.push = 1'b1;
      rq_push_data = bq_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      current_id     <= '0;
      idle_flag      <= 1'b1;
      status         <= 1'b0;
      m_tvalid       <= 1'b0;
      slice_length   <= TIME_W'(10);
      tick_increment <= TIME_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SLICE_LENGTH:   slice_length   <= cfg_data;
          CFG_TICK_INCREMENT: tick_increment <= cfg_data;
          default: ;
        endcase
      end
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r  <= s_tuser;
            tid_r <= s_tdata[ID_W-1:0];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= 1'b0;
          state  <= S_RESULT;
          if (dispatch) begin
            current_id <= rq_stat.empty ? '0 : rq_head;
            idle_flag  <= rq_stat.empty;
          end else if (rq_ctrl.pop) begin
            current_id <= rq_head;
          end
          unique case (op_r)
            OP_ADD_READY:  status <= rq_stat.full;
            OP_BLOCKED:    status <= !idle_flag && bq_stat.full;
            OP_NOTIFY_ONE: status <= !bq_stat.empty && rq_stat.full;
            OP_WAKE_ALL:   state  <= S_WALK;
            default: ;
          endcase
        end
        S_WALK: begin
          if (bq_stat.empty) begin
            status <= 1'b0;
            state  <= S_RESULT;
          end else if (rq_stat.full) begin
            status <= 1'b1;
            state  <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (load_result) begin
            m_tdata  <= {5'b0, RC_W'(rq_stat.fill), status, idle_flag,
                         idle_flag ? {ID_W{1'b0}} : current_id};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_id_zero: assert property (@(posedge clk) disable iff (rst)
    idle_flag |-> (current_id == '0))
    else $error("idle with nonzero running thread");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (rq_stat.fill <= FILL_W'(MAX_THREADS)) && (bq_stat.fill <= FILL_W'(MAX_THREADS)))
    else $error("queue fill beyond depth");

  a_walk_no_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> (rq_stat.fill >= $past(rq_stat.fill)))
    else $error("ready queue shrank during wake-all walk");

  a_walk_conserve: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=>
      (rq_stat.fill + bq_stat.fill == $past(rq_stat.fill) + $past(bq_stat.fill)))
    else $error("thread lost or created during wake-all walk");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import rrts_pkg::*;

  // op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_NOP6 = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP7 = 3'd7;
  localparam int NUM_SETTINGS  = 8;
  localparam int PHASE_BEATS   = 250;

  // view of the scheduler after one event, laid out as m_tdata[10:0]
  typedef struct packed {
    logic [RC_W-1:0] ready_count;
    logic            status;
    logic            idle;
    logic [ID_W-1:0] running_id;
  } sched_snap_t;

  class sched_tracker;
    logic [TIME_W-1:0] slice_len;
    logic [TIME_W-1:0] tick_inc;
    logic [ID_W-1:0]   ready_q[$];
    logic [ID_W-1:0]   blocked_q[$];
    logic [ID_W-1:0]   cur_id;
    bit                idle;
    logic [TIME_W-1:0] used[MAX_THREADS];
    sched_snap_t       snap_q[$];
    int                errors;
    int                checked;
    int                refused;
    int                op_seen[8];

    function new();
      slice_len = 16'd10;
      tick_inc  = 16'd1;
      cur_id    = '0;
      idle      = 1'b1;
      foreach (used[i]) used[i] = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      errors  = 0;
      checked = 0;
      refused = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
      case (idx)
        CFG_SLICE_LENGTH:   slice_len = val;
        CFG_TICK_INCREMENT: tick_inc  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return snap_q.size();
    endfunction

    // hand the CPU to the ready queue head, or go idle
    function void take_next();
      if (ready_q.size() > 0) begin
        cur_id = ready_q[0];
        ready_q.delete(0);
        idle   = 1'b0;
      end else begin
        cur_id = '0;
        idle   = 1'b1;
      end
    endfunction

    function void apply_event(logic [OP_W-1:0] op, logic [ID_W-1:0] tid);
      logic [TIME_W:0]  total;
      logic [ID_W-1:0]  prev;
      sched_snap_t      s;
      bit               flag;
      flag = 1'b0;
      op_seen[op]++;
      case (op)
        OP_ADD_READY: begin
          if (ready_q.size() >= MAX_THREADS) flag = 1'b1;
          else ready_q = {ready_q, tid};
        end
        OP_TICK: begin
          if (idle) begin
            take_next();
          end else begin
            total = used[cur_id] + tick_inc;
            if (total >= slice_len) begin
              used[cur_id] = '0;
              // head leaves first, so the rotation never overflows
              if (ready_q.size() > 0) begin
                prev   = cur_id;
                cur_id = ready_q[0];
                ready_q.delete(0);
                ready_q = {ready_q, prev};
              end
            end else begin
              used[cur_id] = total[TIME_W-1:0];
            end
          end
        end
        OP_FINISHED: take_next();
        OP_BLOCKED: begin
          if (!idle) begin
            if (blocked_q.size() >= MAX_THREADS) flag = 1'b1;
            else blocked_q = {blocked_q, cur_id};
          end
          take_next();
        end
        OP_NOTIFY_ONE: begin
          if (blocked_q.size() > 0) begin
            if (ready_q.size() >= MAX_THREADS) flag = 1'b1;
            else begin
              ready_q = {ready_q, blocked_q[0]};
              blocked_q.delete(0);
            end
          end
        end
        OP_WAKE_ALL: begin
          while (blocked_q.size() > 0 && !flag) begin
            if (ready_q.size() >= MAX_THREADS) flag = 1'b1;
            else begin
              ready_q = {ready_q, blocked_q[0]};
              blocked_q.delete(0);
            end
          end
        end
        default: ;
      endcase
      if (flag) refused++;
      s.running_id  = idle ? '0 : cur_id;
      s.idle        = idle;
      s.status      = flag;
      s.ready_count = RC_W'(ready_q.size());
      snap_q = {snap_q, s};
    endfunction

    function void field_check(string name, logic [4:0] want, logic [4:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void compare_snapshot(logic [15:0] data);
      sched_snap_t want;
      sched_snap_t got;
      got = data[10:0];
      if (snap_q.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing predicted, expected none got %h",
                 $time, data);
        return;
      end
      want = snap_q[0];
      snap_q.delete(0);
      checked++;
      field_check("running_id", 5'(want.running_id), 5'(got.running_id));
      field_check("running_idle", 5'(want.idle), 5'(got.idle));
      field_check("status", 5'(want.status), 5'(got.status));
      field_check("ready_count", want.ready_count, got.ready_count);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [3:0] thread_id, [7:4] zero
  logic [2:0]           s_tuser;   // [2:0] op
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;   // [3:0] running_id, [4] running_idle, [5] status,
                                   // [10:6] ready_count, [15:11] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  sched_tracker tracker = new();
  int           items_sent = 0;
  bit           long_hold_req = 1'b0;

  round_robin_thread_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("round_robin_thread_scheduler test failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_W-1:0] rand_tid();
    return ID_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return OP_ADD_READY;
    if (r < 62) return OP_TICK;
    if (r < 72) return OP_FINISHED;
    if (r < 83) return OP_BLOCKED;
    if (r < 89) return OP_NOTIFY_ONE;
    if (r < 95) return OP_WAKE_ALL;
    if (r < 98) return OP_NOP6;
    return OP_NOP7;
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [ID_W-1:0] tid);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {4'b0000, tid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.apply_event(op, tid);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(input int quota);
    int start;
    int n;
    int unsigned r;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        // pile up the ready queue past its depth
        n = $urandom_range(12, 18);
        repeat (n) send(OP_ADD_READY, rand_tid());
        if ($urandom_range(0, 1)) send(OP_WAKE_ALL, rand_tid());
      end else if (r < 26) begin
        // park many threads so the blocked queue fills
        n = $urandom_range(4, 20);
        repeat (n) begin
          send(OP_ADD_READY, rand_tid());
          if ($urandom_range(0, 3) == 0) send(OP_TICK, rand_tid());
          send(OP_BLOCKED, rand_tid());
        end
      end else if (r < 36) begin
        n = $urandom_range(1, 4);
        repeat (n) send($urandom_range(0, 1) ? OP_NOTIFY_ONE : OP_WAKE_ALL, rand_tid());
      end else if (r < 42) begin
        n = $urandom_range(3, 16);
        repeat (n) send(OP_FINISHED, rand_tid());
      end else if (r < 44) begin
        wait_drain();
      end else begin
        n = $urandom_range(5, 20);
        repeat (n) send(pick_op(), rand_tid());
      end
    end
  endtask

  // result side: random ready pattern, plus one long hold-off on request
  initial begin : sink_pacing
    int unsigned r;
    int unsigned len;
    int unsigned hold_cycles;
    m_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 300) begin
          @(negedge clk);
          m_tready = 1'b0;
          hold_cycles++;
        end
      end else if (r < 60) begin
        len = $urandom_range(1, 24);
        repeat (len) begin
          @(negedge clk);
          m_tready = 1'b1;
        end
      end else begin
        len = (r < 95) ? $urandom_range(1, 4) : $urandom_range(15, 60);
        repeat (len) begin
          @(negedge clk);
          m_tready = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.compare_snapshot(m_tdata);
  end

  initial begin : stimulus
    logic [TIME_W-1:0] slice_set[NUM_SETTINGS];
    logic [TIME_W-1:0] inc_set[NUM_SETTINGS];
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    // setting 0 is the reset value; the last one is drawn at random
    slice_set = '{16'd10, 16'd0, 16'd65535, 16'd65535, 16'd3, 16'd1, 16'd0, 16'd2};
    inc_set   = '{16'd1, 16'd1, 16'd65535, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd1};
    slice_set[NUM_SETTINGS-1] = TIME_W'($urandom_range(0, 12));
    inc_set[NUM_SETTINGS-1]   = TIME_W'($urandom_range(0, 4));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty-queue corner cases, idle ops, no-op codes, then a short run
    send(OP_NOTIFY_ONE, 4'd0);
    send(OP_WAKE_ALL, 4'd15);
    send(OP_TICK, 4'd0);
    send(OP_FINISHED, 4'd15);
    send(OP_BLOCKED, 4'd0);
    send(OP_NOP6, 4'd15);
    send(OP_NOP7, 4'd0);
    send(OP_ADD_READY, 4'd0);
    send(OP_ADD_READY, 4'd15);
    send(OP_ADD_READY, 4'd10);
    send(OP_BLOCKED, 4'd5);
    send(OP_BLOCKED, 4'd5);
    send(OP_NOTIFY_ONE, 4'd5);
    send(OP_BLOCKED, 4'd5);
    send(OP_TICK, 4'd5);
    send(OP_WAKE_ALL, 4'd5);
    send(OP_FINISHED, 4'd5);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph > 0) begin
        wait_drain();
        repeat (8) @(posedge clk);
        write_reg(CFG_SLICE_LENGTH, slice_set[ph]);
        write_reg(CFG_TICK_INCREMENT, inc_set[ph]);
      end
      if (ph == 2) long_hold_req = 1'b1;
      run_phase(PHASE_BEATS);
    end

    wait_drain();
    repeat (30) @(posedge clk);
    $display("%0d result beats checked over %0d slice settings, %0d with a refused append",
             tracker.checked, NUM_SETTINGS, tracker.refused);
    $display("ops: add %0d tick %0d finish %0d block %0d wake %0d wake-all %0d no-op %0d",
             tracker.op_seen[OP_ADD_READY], tracker.op_seen[OP_TICK],
             tracker.op_seen[OP_FINISHED], tracker.op_seen[OP_BLOCKED],
             tracker.op_seen[OP_NOTIFY_ONE], tracker.op_seen[OP_WAKE_ALL],
             tracker.op_seen[OP_NOP6] + tracker.op_seen[OP_NOP7]);
    if (tracker.errors == 0) begin
      $display("round_robin_thread_scheduler test passed");
    end else begin
      $display("round_robin_thread_scheduler test failed");
    end
    $finish;
  end

endmodule
